### sv/prg_pkg.sv
// Package: shared types, constants and state codes for the pre-trade risk gate.
`default_nettype none
package prg_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned MONEY_W  = 48;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned SHARE_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned QUO_W    = 48;
    localparam int unsigned DIV_CNT_W = 6;

    localparam longint unsigned WINDOW_NS = 64'd1000000000;
    localparam longint unsigned MIN_PRICE_NUM = 64'd1000;

    // Parameter defaults
    localparam longint unsigned PRICE_SCALE_DEF     = 64'd1000000;
    localparam longint unsigned MAX_LOSS_STREAK_DEF = 64'd5;
    localparam longint unsigned FEED_A_STALE_NS_DEF = 64'd2000000000;
    localparam longint unsigned FEED_B_STALE_NS_DEF = 64'd2000000000;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_EVAL      = 3'd0,
        CMD_FEED_A    = 3'd1,
        CMD_FEED_B    = 3'd2,
        CMD_KILL_SET  = 3'd3,
        CMD_KILL_CLR  = 3'd4,
        CMD_FILL      = 3'd5,
        CMD_PNL       = 3'd6,
        CMD_NOP       = 3'd7
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 4'd0,
        ST_KILL    = 4'd1,
        ST_RATE    = 4'd2,
        ST_LOSS    = 4'd3,
        ST_DRAWDN  = 4'd4,
        ST_STREAK  = 4'd5,
        ST_STALE_A = 4'd6,
        ST_STALE_B = 4'd7,
        ST_SPREAD  = 4'd8,
        ST_CONF    = 4'd9,
        ST_PRICE   = 4'd10,
        ST_POS     = 4'd11,
        ST_TOTAL   = 4'd12
    } status_t;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_ORDERS  = 3'd0,
        REG_MAX_SHARES  = 3'd1,
        REG_MAX_LOSS    = 3'd2,
        REG_MAX_DRAWDN  = 3'd3,
        REG_MAX_POS     = 3'd4,
        REG_MAX_TOTAL   = 3'd5,
        REG_MAX_SPREAD  = 3'd6,
        REG_MIN_CONF    = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH,
        S_OUT
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture the item
        logic check;      // run check chain, register verdict
        logic div_start;  // load divider
        logic div_step;   // one quotient bit
        logic finish;     // size order and commit state
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;   // evaluation passed all checks up to sizing
        logic div_done;
    } dp_status_t;

endpackage
`default_nettype wire

### sv/prg_ctrl.sv
// Controller: sequences one item through check, divide, finish and output.
`default_nettype none
module prg_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output prg_pkg::dp_cmd_t          cmd,
    input  wire prg_pkg::dp_status_t  stat
);
    import prg_pkg::*;

    ctl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:  state_next = S_DIV;
            S_DIV:
            begin
                if (!stat.need_div || stat.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: state_next = S_OUT;
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = in_valid ? S_CHECK : S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                cmd.div_start = 1'b1;
            end
            S_DIV:    cmd.div_step = stat.need_div && !stat.div_done;
            S_FINISH: cmd.finish = 1'b1;
            S_OUT:
            begin
                out_valid = 1'b1;
                in_stall = out_stall;
                cmd.load = in_valid && !out_stall;
            end
            default:  cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

### sv/prg_dp.sv
// Datapath: registers, check chain, restoring divider and state updates.
`default_nettype none
module prg_dp #(
    parameter longint unsigned PRICE_SCALE     = prg_pkg::PRICE_SCALE_DEF,
    parameter longint unsigned MAX_LOSS_STREAK = prg_pkg::MAX_LOSS_STREAK_DEF,
    parameter longint unsigned FEED_A_STALE_NS = prg_pkg::FEED_A_STALE_NS_DEF,
    parameter longint unsigned FEED_B_STALE_NS = prg_pkg::FEED_B_STALE_NS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire prg_pkg::dp_cmd_t               cmd_i,
    output prg_pkg::dp_status_t                 stat,
    input  wire logic                           cfg_we,
    input  wire logic [prg_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [prg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [prg_pkg::CMD_W-1:0]      cmd,
    input  wire logic [63:0]                    now_ns,
    input  wire logic [31:0]                    order_price,
    input  wire logic [31:0]                    req_shares,
    input  wire logic [31:0]                    spread,
    input  wire logic [15:0]                    confidence,
    input  wire logic signed [47:0]             market_exposure,
    input  wire logic signed [47:0]             amount,
    output logic [prg_pkg::STATUS_W-1:0]        status,
    output logic [31:0]                         approved_shares,
    output logic                                kill_active
);
    import prg_pkg::*;

    localparam logic signed [49:0] S48_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] S48_MIN = -50'sh0_8000_0000_0000;

    // Configuration registers
    logic [15:0]        max_orders_reg;
    logic [31:0]        max_shares_reg;
    logic [46:0]        max_loss_reg;
    logic [46:0]        max_dd_reg;
    logic signed [47:0] max_pos_reg;
    logic signed [47:0] max_tot_reg;
    logic [31:0]        max_spread_reg;
    logic [15:0]        min_conf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_orders_reg <= 16'd50;
            max_shares_reg <= 32'd1000;
            max_loss_reg   <= 47'd500000000;
            max_dd_reg     <= 47'd500000000;
            max_pos_reg    <= 48'sd100000000;
            max_tot_reg    <= 48'sd1000000000;
            max_spread_reg <= 32'd50000;
            min_conf_reg   <= 16'd32768;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_MAX_ORDERS: max_orders_reg <= cfg_data[15:0];
                REG_MAX_SHARES: max_shares_reg <= cfg_data[31:0];
                REG_MAX_LOSS:   max_loss_reg   <= cfg_data[46:0];
                REG_MAX_DRAWDN: max_dd_reg     <= cfg_data[46:0];
                REG_MAX_POS:    max_pos_reg    <= cfg_data[47:0];
                REG_MAX_TOTAL:  max_tot_reg    <= cfg_data[47:0];
                REG_MAX_SPREAD: max_spread_reg <= cfg_data[31:0];
                REG_MIN_CONF:   min_conf_reg   <= cfg_data[15:0];
                default:        max_orders_reg <= max_orders_reg;
            endcase
        end
    end

    // Captured item
    cmd_t               cmd_reg;
    logic [63:0]        now_reg;
    logic [31:0]        price_reg;
    logic [31:0]        req_reg;
    logic [31:0]        spread_reg;
    logic [15:0]        conf_reg;
    logic signed [47:0] mexp_reg;
    logic signed [47:0] amt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            cmd_reg    <= cmd_t'(cmd);
            now_reg    <= now_ns;
            price_reg  <= order_price;
            req_reg    <= req_shares;
            spread_reg <= spread;
            conf_reg   <= confidence;
            mexp_reg   <= market_exposure;
            amt_reg    <= amount;
        end
    end

    // Risk state
    logic               kill_reg;
    logic [63:0]        win_start_reg;
    logic [15:0]        win_cnt_reg;
    logic signed [47:0] pnl_reg;
    logic signed [47:0] peak_reg;
    logic [15:0]        streak_reg;
    logic signed [47:0] tot_reg;
    logic [63:0]        feed_a_reg;
    logic [63:0]        feed_b_reg;

    // Check chain (combinational on captured item and state)
    logic               win_restart;
    logic [15:0]        cnt_eff;
    logic [64:0]        win_end;
    logic [64:0]        stale_a_end;
    logic [64:0]        stale_b_end;
    logic signed [49:0] room_m;
    logic signed [49:0] room_t;
    logic signed [49:0] dd;
    status_t            chk_status;
    logic               chk_kill;

    assign win_end     = {1'b0, win_start_reg} + 65'(WINDOW_NS);
    assign stale_a_end = {1'b0, feed_a_reg} + 65'(FEED_A_STALE_NS);
    assign stale_b_end = {1'b0, feed_b_reg} + 65'(FEED_B_STALE_NS);
    assign win_restart = (win_start_reg == 64'd0) || ({1'b0, now_reg} >= win_end);
    assign cnt_eff     = win_restart ? 16'd0 : win_cnt_reg;
    assign room_m      = 50'(max_pos_reg) - 50'(mexp_reg);
    assign room_t      = 50'(max_tot_reg) - 50'(tot_reg);
    assign dd          = 50'(peak_reg) - 50'(pnl_reg);

    always_comb
    begin
        chk_status = ST_OK;
        chk_kill = 1'b0;
        if (kill_reg)
            chk_status = ST_KILL;
        else if (max_orders_reg != 16'd0 && cnt_eff >= max_orders_reg)
            chk_status = ST_RATE;
        else if (50'(pnl_reg) <= -$signed({3'b000, max_loss_reg}))
        begin
            chk_status = ST_LOSS;
            chk_kill = 1'b1;
        end
        else if (dd >= $signed({3'b000, max_dd_reg}))
        begin
            chk_status = ST_DRAWDN;
            chk_kill = 1'b1;
        end
        else if (MAX_LOSS_STREAK > 0 && 64'(streak_reg) >= MAX_LOSS_STREAK)
        begin
            chk_status = ST_STREAK;
            chk_kill = 1'b1;
        end
        else if (FEED_A_STALE_NS > 0 && feed_a_reg != 64'd0
                 && {1'b0, now_reg} > stale_a_end)
            chk_status = ST_STALE_A;
        else if (FEED_B_STALE_NS > 0 && feed_b_reg != 64'd0
                 && {1'b0, now_reg} > stale_b_end)
            chk_status = ST_STALE_B;
        else if (spread_reg > max_spread_reg)
            chk_status = ST_SPREAD;
        else if (conf_reg < min_conf_reg)
            chk_status = ST_CONF;
        else if ({32'd0, price_reg} * MIN_PRICE_NUM <= PRICE_SCALE)
            chk_status = ST_PRICE;
        else if (room_m <= 50'sd0)
            chk_status = ST_POS;
        else if (room_t <= 50'sd0)
            chk_status = ST_TOTAL;
    end

    // Verdict registers
    status_t     vstat_reg;
    logic        need_div_reg;
    logic        restart_reg;

    // Divider: restoring, one quotient bit per cycle
    logic [QUO_W-1:0]     quo_reg;
    logic [32:0]          rem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [32:0]          rem_shift;
    logic [QUO_W-1:0]     dividend;

    assign dividend  = (room_m < room_t) ? room_m[QUO_W-1:0] : room_t[QUO_W-1:0];
    assign rem_shift = {rem_reg[31:0], quo_reg[QUO_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd_i.div_start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dcnt_reg <= DIV_CNT_W'(QUO_W);
        end
        else if (cmd_i.div_step)
        begin
            if (rem_shift >= {1'b0, price_reg})
            begin
                rem_reg <= rem_shift - {1'b0, price_reg};
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vstat_reg    <= ST_OK;
            need_div_reg <= 1'b0;
            restart_reg  <= 1'b0;
        end
        else if (cmd_i.check)
        begin
            vstat_reg    <= chk_status;
            need_div_reg <= (cmd_reg == CMD_EVAL) && (chk_status == ST_OK);
            restart_reg  <= win_restart;
        end
    end

    assign stat.need_div = need_div_reg;
    assign stat.div_done = (dcnt_reg == '0);

    // Sizing
    logic [31:0] allowed;
    logic [31:0] alw_cap;
    assign allowed = (quo_reg[QUO_W-1:32] != '0) ? 32'hFFFF_FFFF : quo_reg[31:0];
    assign alw_cap = (max_shares_reg != 32'd0 && allowed > max_shares_reg)
                     ? max_shares_reg : allowed;

    // Accumulator sums
    logic signed [49:0] pnl_sum;
    logic signed [49:0] tot_sum;
    logic signed [47:0] pnl_sat;
    logic signed [47:0] tot_sat;
    assign pnl_sum = 50'(pnl_reg) + 50'(amt_reg);
    assign tot_sum = 50'(tot_reg) + 50'(amt_reg);
    assign pnl_sat = (pnl_sum > S48_MAX) ? S48_MAX[47:0] :
                     (pnl_sum < S48_MIN) ? S48_MIN[47:0] : pnl_sum[47:0];
    assign tot_sat = (tot_sum > S48_MAX) ? S48_MAX[47:0] :
                     (tot_sum < S48_MIN) ? S48_MIN[47:0] : tot_sum[47:0];

    // Result and state commit
    status_t     res_stat_reg;
    logic [31:0] res_sh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kill_reg      <= 1'b0;
            win_start_reg <= '0;
            win_cnt_reg   <= '0;
            pnl_reg       <= '0;
            peak_reg      <= '0;
            streak_reg    <= '0;
            tot_reg       <= '0;
            feed_a_reg    <= '0;
            feed_b_reg    <= '0;
            res_stat_reg  <= ST_OK;
            res_sh_reg    <= '0;
        end
        else if (cmd_i.finish)
        begin
            res_stat_reg <= ST_OK;
            res_sh_reg   <= '0;
            case (cmd_reg)
                CMD_EVAL:
                begin
                    if (vstat_reg != ST_KILL && restart_reg)
                    begin
                        win_start_reg <= now_reg;
                        win_cnt_reg   <= '0;
                    end
                    if (vstat_reg == ST_LOSS || vstat_reg == ST_DRAWDN
                        || vstat_reg == ST_STREAK)
                    begin
                        kill_reg <= 1'b1;
                    end
                    if (vstat_reg != ST_OK)
                        res_stat_reg <= vstat_reg;
                    else if (alw_cap == 32'd0)
                        res_stat_reg <= ST_TOTAL;
                    else
                    begin
                        res_sh_reg <= (req_reg < alw_cap) ? req_reg : alw_cap;
                        if (restart_reg)
                            win_cnt_reg <= 16'd1;
                        else if (win_cnt_reg != 16'hFFFF)
                            win_cnt_reg <= win_cnt_reg + 16'd1;
                    end
                end
                CMD_FEED_A:   feed_a_reg <= now_reg;
                CMD_FEED_B:   feed_b_reg <= now_reg;
                CMD_KILL_SET: kill_reg <= 1'b1;
                CMD_KILL_CLR: kill_reg <= 1'b0;
                CMD_FILL:     tot_reg <= tot_sat;
                CMD_PNL:
                begin
                    pnl_reg <= pnl_sat;
                    if (pnl_sat > peak_reg)
                        peak_reg <= pnl_sat;
                    if (amt_reg < 48'sd0)
                    begin
                        if (streak_reg != 16'hFFFF)
                            streak_reg <= streak_reg + 16'd1;
                    end
                    else if (amt_reg > 48'sd0)
                        streak_reg <= '0;
                end
                default: res_sh_reg <= '0;
            endcase
        end
    end

    assign status          = res_stat_reg;
    assign approved_shares = res_sh_reg;
    assign kill_active     = kill_reg;

endmodule
`default_nettype wire

### sv/pretrade_risk_gate.sv
// Top level of the pre-trade risk gate: controller plus datapath.
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall  | cmd now_ns order_price req_shares spread ...
//  output  | out       | out_valid/out_stall| status approved_shares kill_active
//  config  | in        | cfg_we             | cfg_idx cfg_data
// An item passes the check, divide, finish and output states; an evaluation
// reaching sizing runs the 48-step restoring divider, one quotient bit a cycle.
// Reset clears all risk state and loads register defaults; no clearing pass.
// A held output stalls the input; the next item is taken in the cycle the
// result transfers.
`default_nettype none
module pretrade_risk_gate #(
    parameter longint unsigned PRICE_SCALE     = prg_pkg::PRICE_SCALE_DEF,
    parameter longint unsigned MAX_LOSS_STREAK = prg_pkg::MAX_LOSS_STREAK_DEF,
    parameter longint unsigned FEED_A_STALE_NS = prg_pkg::FEED_A_STALE_NS_DEF,
    parameter longint unsigned FEED_B_STALE_NS = prg_pkg::FEED_B_STALE_NS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [prg_pkg::CMD_W-1:0]      cmd,
    input  wire logic [63:0]                    now_ns,
    input  wire logic [31:0]                    order_price,
    input  wire logic [31:0]                    req_shares,
    input  wire logic [31:0]                    spread,
    input  wire logic [15:0]                    confidence,
    input  wire logic signed [47:0]             market_exposure,
    input  wire logic signed [47:0]             amount,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [prg_pkg::STATUS_W-1:0]        status,
    output logic [31:0]                         approved_shares,
    output logic                                kill_active,
    input  wire logic                           cfg_we,
    input  wire logic [prg_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [prg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import prg_pkg::*;

    dp_cmd_t    dcmd;
    dp_status_t dstat;

    prg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (dcmd),
        .stat      (dstat)
    );

    prg_dp #(
        .PRICE_SCALE     (PRICE_SCALE),
        .MAX_LOSS_STREAK (MAX_LOSS_STREAK),
        .FEED_A_STALE_NS (FEED_A_STALE_NS),
        .FEED_B_STALE_NS (FEED_B_STALE_NS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_i           (dcmd),
        .stat            (dstat),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .now_ns          (now_ns),
        .order_price     (order_price),
        .req_shares      (req_shares),
        .spread          (spread),
        .confidence      (confidence),
        .market_exposure (market_exposure),
        .amount          (amount),
        .status          (status),
        .approved_shares (approved_shares),
        .kill_active     (kill_active)
    );

endmodule
`default_nettype wire
